// ----- sv/mrjb_pkg.sv -----
// Shared types, constants and helpers of the recovery journal builder.
// No dependencies.
`default_nettype none

package mrjb_pkg;

  localparam int unsigned Channels     = 16;
  localparam int unsigned NoteSlots    = 16;
  localparam int unsigned OffOctets    = 16;
  localparam int unsigned HeaderBytes  = 3;
  localparam int unsigned ChanFixBytes = 5;

  localparam logic [3:0] RangeLowRst  = 4'hf;
  localparam logic [3:0] RangeHighRst = 4'h1;
  localparam logic [7:0] TocChapterN  = 8'h08;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_WR,
    ST_RD_SCAN,
    ST_RD_MEM,
    ST_RD_OUT
  } mrjb_state_e;

  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_NOTE,
    SRC_OFF
  } mrjb_src_e;

  typedef struct packed {
    logic note_we;
    logic note_re;
    logic off_we;
    logic off_re;
  } mrjb_mem_ctl_t;

  // Number of off-bit octets in LOW..HIGH, zero for an empty range.
  function automatic logic [4:0] off_count(input logic [3:0] lo, input logic [3:0] hi);
    logic [4:0] n;
    begin
      n = (hi < lo) ? 5'd0 : (5'(hi) - 5'(lo) + 5'd1);
      return n;
    end
  endfunction

  // Channel header + TOC + chapter N, in bytes.
  function automatic logic [8:0] chan_size(input logic [6:0] cnt, input logic [3:0] lo,
                                           input logic [3:0] hi);
    logic [8:0] s;
    begin
      s = 9'(ChanFixBytes) + {1'b0, cnt, 1'b0} + 9'(off_count(lo, hi));
      return s;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/mrjb_in_if.sv -----
// Input channel of the journal builder: note events and byte read requests.
// Depends on nothing.
`default_nettype none

interface mrjb_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [4:0]  midi_channel;
  logic [6:0]  note_number;
  logic [6:0]  note_velocity;
  logic [15:0] sequence_number;

  modport source (output valid, func, midi_channel, note_number, note_velocity,
                  sequence_number, input ready);
  modport sink   (input valid, func, midi_channel, note_number, note_velocity,
                  sequence_number, output ready);
endinterface

`default_nettype wire

// ----- sv/mrjb_out_if.sv -----
// Output channel of the journal builder: one journal byte per transaction.
// Depends on nothing.
`default_nettype none

interface mrjb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] journal_byte;
  logic       last_byte;

  modport source (output valid, journal_byte, last_byte, input ready);
  modport sink   (input valid, journal_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/mrjb_store.sv -----
// Note slot memory and off-bit memory, the latter with per-entry valid bits; registered reads.
// Depends on mrjb_pkg.
`default_nettype none

module mrjb_store
  import mrjb_pkg::*;
#(
  parameter int unsigned CHANNELS   = Channels,
  parameter int unsigned NOTE_SLOTS = NoteSlots,
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned NDEPTH = CHANNELS * NOTE_SLOTS,
  localparam int unsigned NA_W   = (NDEPTH > 1) ? $clog2(NDEPTH) : 1,
  localparam int unsigned OA_W   = CH_W + 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mrjb_mem_ctl_t       ctl_i,
  input  wire logic [NA_W-1:0]     note_addr_i,
  input  wire logic [13:0]         note_wdata_i,
  input  wire logic [OA_W-1:0]     off_addr_i,
  input  wire logic [7:0]          off_wdata_i,
  output logic      [13:0]         note_rdata_o,
  output logic      [7:0]          off_rdata_o
);

  localparam int unsigned ODEPTH = 1 << OA_W;

  logic [13:0] note_mem [NDEPTH];
  logic [7:0]  off_mem  [ODEPTH];
  logic [ODEPTH-1:0] off_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.note_we) begin
      note_mem[note_addr_i] <= note_wdata_i;
    end
    if (ctl_i.note_re) begin
      note_rdata_o <= note_mem[note_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.off_we) begin
      off_mem[off_addr_i] <= off_wdata_i;
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_vld_q   <= '0;
      off_rdata_o <= '0;
    end else begin
      if (ctl_i.off_we) begin
        off_vld_q[off_addr_i] <= 1'b1;
      end
      if (ctl_i.off_re) begin
        off_rdata_o <= off_vld_q[off_addr_i] ? off_mem[off_addr_i] : 8'h00;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/midi_recovery_journal_builder_unit.sv -----
// Top level of the RTP-MIDI recovery journal builder (chapter N).
// Depends on mrjb_pkg, mrjb_in_if, mrjb_out_if and mrjb_store.
//
//   port    dir  modport  carries
//   in_i    in   sink     func, midi_channel, note_number, note_velocity, sequence_number
//   out_o   out  source   journal_byte, last_byte
//
// A note event goes through accept, off-bit memory read and write back.
// A read of a journal header byte goes straight to the output stage; inside
// a channel that was already located the scan resumes at the cached
// channel; after an event or a wrap the channel walk starts again at the
// first channel, one channel per cycle. Note and off-bit bytes add a
// memory read state. Reset is asynchronous and needs no clearing pass.
// The input is not taken while a read waits for the output register.
`default_nettype none

module midi_recovery_journal_builder_unit
  import mrjb_pkg::*;
#(
  parameter int unsigned CHANNELS   = Channels,
  parameter int unsigned NOTE_SLOTS = NoteSlots
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mrjb_in_if.sink    in_i,
  mrjb_out_if.source out_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SC_W   = $clog2(NOTE_SLOTS + 1);
  localparam int unsigned NDEPTH = CHANNELS * NOTE_SLOTS;
  localparam int unsigned NA_W   = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
  localparam int unsigned OA_W   = CH_W + 4;
  localparam int unsigned MAXJ   = HeaderBytes + CHANNELS * (ChanFixBytes + 2 * NOTE_SLOTS
                                   + OffOctets);
  localparam int unsigned TOT_W  = $clog2(MAXJ + 1);
  localparam int unsigned UC_W   = $clog2(CHANNELS + 1);

  // Control state
  mrjb_state_e state_q, state_d;

  // Captured event
  logic [CH_W-1:0]  ev_ch_q;
  logic [6:0]       ev_note_q, ev_vel_q;
  logic [15:0]      ev_seq_q;

  // Journal registers
  logic [CHANNELS-1:0] used_q, used_d;
  logic [UC_W-1:0]     used_cnt_q, used_cnt_d;
  logic [15:0]         seq_q, seq_d;
  logic                a_q, a_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic [TOT_W-1:0]    cursor_q, cursor_d;
  logic [SC_W-1:0]     slot_cnt_q [CHANNELS];
  logic [3:0]          rng_lo_q   [CHANNELS];
  logic [3:0]          rng_hi_q   [CHANNELS];

  // Read walk
  logic [TOT_W-1:0] pos_q, pos_d;
  logic [CH_W-1:0]  scan_ch_q, scan_ch_d;
  logic [TOT_W-1:0] base_q, base_d;
  logic             cache_ok_q, cache_ok_d;
  logic [CH_W-1:0]  cache_ch_q, cache_ch_d;
  logic [TOT_W-1:0] cache_base_q, cache_base_d;
  logic [7:0]       byte_q, byte_d;
  mrjb_src_e        src_q, src_d;
  logic             half_q, half_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  // Memories
  mrjb_mem_ctl_t   mem_ctl;
  logic [NA_W-1:0] note_addr;
  logic [13:0]     note_wdata, note_rdata;
  logic [OA_W-1:0] off_addr;
  logic [7:0]      off_wdata, off_rdata;

  mrjb_store #(
    .CHANNELS   (CHANNELS),
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (mem_ctl),
    .note_addr_i  (note_addr),
    .note_wdata_i (note_wdata),
    .off_addr_i   (off_addr),
    .off_wdata_i  (off_wdata),
    .note_rdata_o (note_rdata),
    .off_rdata_o  (off_rdata)
  );

  // ---------------------------------------------------------------------------
  // Per-channel info, one read port: event channel on write-back, else walk.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0] sel_ch;
  logic [SC_W-1:0] cnt_s;
  logic [3:0]      lo_s, hi_s;
  logic [8:0]      sz_s;

  assign sel_ch = (state_q == ST_EV_WR) ? ev_ch_q : scan_ch_q;
  assign cnt_s  = slot_cnt_q[sel_ch];
  assign lo_s   = rng_lo_q[sel_ch];
  assign hi_s   = rng_hi_q[sel_ch];
  assign sz_s   = chan_size(7'(cnt_s), lo_s, hi_s);

  logic              out_free;
  logic              in_fire, rd_fire, ev_fire, ev_ok;
  logic [CH_W-1:0]   in_ch;
  logic [TOT_W-1:0]  start_pos;
  logic              start_hdr;
  logic [7:0]        hdr_byte;
  logic [3:0]        tot_chan;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;
  assign rd_fire  = in_fire && in_i.func;
  assign ev_ok    = (in_i.midi_channel != 5'd0) && (32'(in_i.midi_channel) <= CHANNELS);
  assign ev_fire  = in_fire && !in_i.func && ev_ok;
  assign in_ch    = CH_W'(in_i.midi_channel - 5'd1);

  // Cursor past the end restarts at the journal header.
  assign start_pos = (cursor_q >= total_q) ? '0 : cursor_q;
  assign start_hdr = start_pos < TOT_W'(HeaderBytes);
  assign tot_chan  = (used_cnt_q == '0) ? 4'd0 : 4'(used_cnt_q - UC_W'(1));

  always_comb begin
    case (start_pos[1:0])
      2'd0:    hdr_byte = {2'b00, a_q, 1'b0, tot_chan};
      2'd1:    hdr_byte = seq_q[15:8];
      default: hdr_byte = seq_q[7:0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Walk decode: does pos_q fall into scan_ch_q, and where inside it.
  // ---------------------------------------------------------------------------
  logic [TOT_W-1:0] sc_end;
  logic             sc_used, sc_hit, sc_last_ch;
  logic [8:0]       sc_p, sc_p5, sc_n2, sc_q;
  logic [9:0]       sc_len;
  logic [4:0]       sc_offc;
  mrjb_src_e        sc_src;
  logic [7:0]       sc_byte;
  logic [NA_W-1:0]  sc_note_addr;
  logic [OA_W-1:0]  sc_off_addr;

  assign sc_used    = used_q[scan_ch_q];
  assign sc_end     = base_q + TOT_W'(sz_s);
  assign sc_hit     = sc_used && (pos_q < sc_end);
  assign sc_last_ch = scan_ch_q == CH_W'(CHANNELS - 1);
  assign sc_p       = 9'(pos_q - base_q);
  assign sc_p5      = sc_p - 9'(ChanFixBytes);
  assign sc_n2      = {1'b0, 7'(cnt_s), 1'b0};
  assign sc_q       = sc_p5 - sc_n2;
  assign sc_len     = {1'b0, sz_s};
  assign sc_offc    = off_count(lo_s, hi_s);
  assign sc_note_addr = NA_W'(int'(scan_ch_q) * NOTE_SLOTS + int'(sc_p5[8:1]));
  assign sc_off_addr  = {scan_ch_q, 4'(lo_s + sc_q[3:0])};

  always_comb begin
    sc_src  = SRC_DIRECT;
    sc_byte = 8'h00;
    if (sc_p < 9'(ChanFixBytes)) begin
      case (sc_p[2:0])
        3'd0:    sc_byte = {1'b0, 4'(scan_ch_q), 1'b0, sc_len[9:8]};
        3'd1:    sc_byte = sc_len[7:0];
        3'd2:    sc_byte = (cnt_s != '0) ? TocChapterN : 8'h00;
        3'd3:    sc_byte = {cnt_s != '0, 7'(cnt_s)};
        default: sc_byte = {lo_s, hi_s};
      endcase
    end else if (sc_p5 < sc_n2) begin
      sc_src = SRC_NOTE;
    end else if (sc_q < 9'(sc_offc)) begin
      sc_src = SRC_OFF;
    end
  end

  // ---------------------------------------------------------------------------
  // Event write-back values.
  // ---------------------------------------------------------------------------
  logic             ev_is_off, ev_full, ev_log;
  logic [3:0]       ev_oct, lo_n, hi_n;
  logic [SC_W-1:0]  cnt_n;
  logic [8:0]       sz_n;

  assign ev_is_off = ev_vel_q == 7'd0;
  assign ev_oct    = ev_note_q[6:3];
  assign ev_full   = cnt_s == SC_W'(NOTE_SLOTS);
  assign ev_log    = !ev_is_off && !ev_full;
  assign lo_n      = (ev_is_off && ev_oct < lo_s) ? ev_oct : lo_s;
  assign hi_n      = (ev_is_off && ev_oct > hi_s) ? ev_oct : hi_s;
  assign cnt_n     = ev_log ? cnt_s + SC_W'(1) : cnt_s;
  assign sz_n      = chan_size(7'(cnt_n), lo_n, hi_n);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ev_fire) begin
          state_d = ST_EV_RD;
        end else if (rd_fire) begin
          state_d = start_hdr ? ST_RD_OUT : ST_RD_SCAN;
        end
      end
      ST_EV_RD:  state_d = ST_EV_WR;
      ST_EV_WR:  state_d = ST_IDLE;
      ST_RD_SCAN: begin
        if (sc_hit) begin
          state_d = (sc_src == SRC_DIRECT) ? ST_RD_OUT : ST_RD_MEM;
        end else if (sc_last_ch) begin
          state_d = ST_RD_OUT;
        end
      end
      ST_RD_MEM: state_d = ST_RD_OUT;
      ST_RD_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs and datapath
  // ---------------------------------------------------------------------------
  assign in_i.ready = state_q == ST_IDLE;

  always_comb begin
    used_d       = used_q;
    used_cnt_d   = used_cnt_q;
    seq_d        = seq_q;
    a_d          = a_q;
    total_d      = total_q;
    cursor_d     = cursor_q;
    pos_d        = pos_q;
    scan_ch_d    = scan_ch_q;
    base_d       = base_q;
    cache_ok_d   = cache_ok_q;
    cache_ch_d   = cache_ch_q;
    cache_base_d = cache_base_q;
    byte_d       = byte_q;
    src_d        = src_q;
    half_d       = half_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    mem_ctl      = '0;
    note_addr    = sc_note_addr;
    note_wdata   = {ev_note_q, ev_vel_q};
    off_addr     = sc_off_addr;
    off_wdata    = off_rdata | (8'h80 >> ev_note_q[2:0]);

    case (state_q)
      ST_IDLE: begin
        if (rd_fire) begin
          pos_d  = start_pos;
          byte_d = hdr_byte;
          if (cache_ok_q && start_pos >= cache_base_q) begin
            scan_ch_d = cache_ch_q;
            base_d    = cache_base_q;
          end else begin
            scan_ch_d = '0;
            base_d    = TOT_W'(HeaderBytes);
          end
        end
      end
      ST_EV_RD: begin
        off_addr       = {ev_ch_q, ev_oct};
        mem_ctl.off_re = 1'b1;
      end
      ST_EV_WR: begin
        off_addr        = {ev_ch_q, ev_oct};
        note_addr       = NA_W'(int'(ev_ch_q) * NOTE_SLOTS + int'(cnt_s));
        mem_ctl.off_we  = ev_is_off;
        mem_ctl.note_we = ev_log;
        used_d[ev_ch_q] = 1'b1;
        a_d             = 1'b1;
        cache_ok_d      = 1'b0;
        if (ev_is_off || ev_log) begin
          seq_d = ev_seq_q;
        end
        if (used_q[ev_ch_q]) begin
          total_d = total_q + TOT_W'(sz_n) - TOT_W'(sz_s);
        end else begin
          total_d    = total_q + TOT_W'(sz_n) + TOT_W'(HeaderBytes) - TOT_W'(HeaderBytes);
          used_cnt_d = used_cnt_q + UC_W'(1);
        end
      end
      ST_RD_SCAN: begin
        if (sc_hit) begin
          byte_d       = sc_byte;
          src_d        = sc_src;
          half_d       = sc_p5[0];
          cache_ok_d   = 1'b1;
          cache_ch_d   = scan_ch_q;
          cache_base_d = base_q;
          mem_ctl.note_re = sc_src == SRC_NOTE;
          mem_ctl.off_re  = sc_src == SRC_OFF;
        end else begin
          if (sc_used) begin
            base_d = sc_end;
          end
          if (sc_last_ch) begin
            byte_d = 8'h00;
          end else begin
            scan_ch_d = scan_ch_q + CH_W'(1);
          end
        end
      end
      ST_RD_MEM: begin
        if (src_q == SRC_NOTE) begin
          byte_d = half_q ? {1'b0, note_rdata[6:0]} : {1'b0, note_rdata[13:7]};
        end else begin
          byte_d = off_rdata;
        end
      end
      ST_RD_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
          out_last_d  = (pos_q + TOT_W'(1)) == total_q;
          cursor_d    = ((pos_q + TOT_W'(1)) == total_q) ? '0 : pos_q + TOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.journal_byte = out_byte_q;
  assign out_o.last_byte    = out_last_q;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      used_cnt_q  <= '0;
      seq_q       <= '0;
      a_q         <= 1'b0;
      total_q     <= TOT_W'(HeaderBytes);
      cursor_q    <= '0;
      cache_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        slot_cnt_q[i] <= '0;
        rng_lo_q[i]   <= RangeLowRst;
        rng_hi_q[i]   <= RangeHighRst;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      used_cnt_q  <= used_cnt_d;
      seq_q       <= seq_d;
      a_q         <= a_d;
      total_q     <= total_d;
      cursor_q    <= cursor_d;
      cache_ok_q  <= cache_ok_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_EV_WR) begin
        slot_cnt_q[ev_ch_q] <= cnt_n;
        rng_lo_q[ev_ch_q]   <= lo_n;
        rng_hi_q[ev_ch_q]   <= hi_n;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ev_fire) begin
      ev_ch_q   <= in_ch;
      ev_note_q <= in_i.note_number;
      ev_vel_q  <= in_i.note_velocity;
      ev_seq_q  <= in_i.sequence_number;
    end
    pos_q        <= pos_d;
    scan_ch_q    <= scan_ch_d;
    base_q       <= base_d;
    cache_ch_q   <= cache_ch_d;
    cache_base_q <= cache_base_d;
    byte_q       <= byte_d;
    src_q        <= src_d;
    half_q       <= half_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
  end

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q < total_q) || (cursor_q == '0))
    else $error("read cursor beyond journal end");

  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == 32'(used_cnt_q))
    else $error("used channel count out of step with used mask");

  a_no_slot_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.note_we |-> (cnt_s < SC_W'(NOTE_SLOTS)))
    else $error("note slot written past the end of the list");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_OUT && out_free && (pos_q + TOT_W'(1)) == total_q) |=>
    (cursor_q == '0))
    else $error("cursor did not wrap after the last byte");
`endif

endmodule

`default_nettype wire
